[rtl/vn_pkg.sv]
package vn_pkg;

  localparam int IN_FRAC_BITS = 16;

  // Threshold reset is 0.001 in the input format, rounded to nearest.
  localparam logic [15:0] MIN_MAG_RESET = 16'(((1 << IN_FRAC_BITS) + 500) / 1000);

  localparam int PADDR_W = 3;
  localparam logic REG_MIN_MAG = 1'b0;

  localparam int FRONT_STAGES = 5;
  localparam int SQRT_STAGES  = 32;
  localparam int DIV_STAGES   = 31;
  localparam int LANE_LATENCY = DIV_STAGES + 1;
  localparam int PIPE_DEPTH   = FRONT_STAGES + SQRT_STAGES + LANE_LATENCY;

  typedef struct packed {
    logic signed [31:0] comp_x;
    logic signed [31:0] comp_y;
    logic signed [31:0] comp_z;
  } vec_word_t;

  typedef struct packed {
    logic signed [31:0] unit_x;
    logic signed [31:0] unit_y;
    logic signed [31:0] unit_z;
    logic               too_short;
  } unit_word_t;

  // Per-vector data that rides along with the magnitude computation.
  typedef struct packed {
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
    logic             short_vec;
    logic [4:0]       k;
  } vn_side_t;

endpackage

[rtl/vector3_normalize.sv]
// Normalizes one signed Q16.16 vector per clock to signed Q2.30 unit components, or returns
// the zero vector with too_short set when the magnitude is at or below min_magnitude. The
// pipeline depth is set by the 32-stage square root and the divider lanes, one per component.
// Throughput is one word per cycle while vec_stall is low. vec_stall rises only when a
// result is held at the output and a second one has already arrived behind it.
module vector3_normalize (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vn_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        vec_valid,
  output logic                        vec_stall,
  input  vn_pkg::vec_word_t           vec,
  output logic                        unit_valid,
  input  logic                        unit_stall,
  output vn_pkg::unit_word_t          unit
);
  import vn_pkg::*;

  logic [15:0] min_magnitude;
  logic [31:0] thr2;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_magnitude <= MIN_MAG_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_MIN_MAG) begin
      min_magnitude <= pwdata[15:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MIN_MAG) ? {16'b0, min_magnitude} : 32'b0;
  assign thr2   = min_magnitude * min_magnitude;

  logic en;
  logic [PIPE_DEPTH:1] vline;
  logic [31:0] comp [3];

  assign en        = !vec_stall;
  assign comp[0]   = vec.comp_x;
  assign comp[1]   = vec.comp_y;
  assign comp[2]   = vec.comp_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      vline <= '0;
    end else if (en) begin
      vline <= {vline[PIPE_DEPTH-1:1], vec_valid};
    end
  end

  // Front end: magnitudes, squares, sum and threshold, normalizing shift.
  vn_side_t    s1_side, s2_side, s3_side, s4_side, s5_side;
  vn_side_t    s3_side_next, s4_side_next;
  logic [63:0] s2_sq [3];
  logic [63:0] s3_sum, s4_sum;
  logic [63:0] s5_sn;
  logic [4:0]  lz_k;

  always_comb begin
    lz_k = '0;
    for (int j = 0; j < 32; j++) begin
      if (s3_sum[2*j +: 2] != 2'b00) begin
        lz_k = 5'(31 - j);
      end
    end
  end

  always_comb begin
    s3_side_next           = s2_side;
    s3_side_next.short_vec = (s2_sq[0] + s2_sq[1] + s2_sq[2]) <= {32'b0, thr2};
    s4_side_next           = s3_side;
    s4_side_next.k         = lz_k;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_side.mag[i] <= comp[i][31] ? 32'(-comp[i]) : comp[i];
        s1_side.neg[i] <= comp[i][31];
        s2_sq[i]       <= s1_side.mag[i] * s1_side.mag[i];
      end
      s1_side.short_vec <= 1'b0;
      s1_side.k         <= '0;
      s2_side           <= s1_side;
      s3_sum            <= s2_sq[0] + s2_sq[1] + s2_sq[2];
      s3_side           <= s3_side_next;
      s4_sum            <= s3_sum;
      s4_side           <= s4_side_next;
      s5_sn             <= s4_sum << {s4_side.k, 1'b0};
      s5_side           <= s4_side;
    end
  end

  logic [31:0] root;
  vn_side_t    sq_side;

  vn_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (s5_sn),
    .side_in  (s5_side),
    .root_out (root),
    .side_out (sq_side)
  );

  logic signed [31:0] lane_unit [3];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    vn_div_lane u_lane (
      .clk  (clk),
      .en   (en),
      .mag  (sq_side.mag[i]),
      .k    (sq_side.k),
      .neg  (sq_side.neg[i]),
      .root (root),
      .unit (lane_unit[i])
    );
  end

  logic [LANE_LATENCY:1] short_line;

  always_ff @(posedge clk) begin
    if (en) begin
      short_line <= {short_line[LANE_LATENCY-1:1], sq_side.short_vec};
    end
  end

  // Merge the lanes; a short vector overrides whatever the lanes produced.
  unit_word_t merged;
  logic       short_out;

  assign short_out        = short_line[LANE_LATENCY];
  assign merged.unit_x    = short_out ? '0 : lane_unit[0];
  assign merged.unit_y    = short_out ? '0 : lane_unit[1];
  assign merged.unit_z    = short_out ? '0 : lane_unit[2];
  assign merged.too_short = short_out;

  // Output register with a skid word behind it.
  unit_word_t out_word, skid_word;
  logic       out_full, skid_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full  <= 1'b0;
      skid_full <= 1'b0;
    end else if (!out_full || !unit_stall) begin
      if (skid_full) begin
        out_full  <= 1'b1;
        skid_full <= 1'b0;
      end else begin
        out_full  <= vline[PIPE_DEPTH];
      end
    end else if (vline[PIPE_DEPTH] && !skid_full) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_full || !unit_stall) begin
      out_word <= skid_full ? skid_word : merged;
    end else if (!skid_full) begin
      skid_word <= merged;
    end
  end

  assign vec_stall  = skid_full;
  assign unit_valid = out_full;
  assign unit       = out_word;

  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    unit_valid && unit.too_short |->
      unit.unit_x == 0 && unit.unit_y == 0 && unit.unit_z == 0)
    else $error("short vector gave nonzero components");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    unit_valid |->
      unit.unit_x <= 32'sd1073741824 && unit.unit_x >= -32'sd1073741824 &&
      unit.unit_y <= 32'sd1073741824 && unit.unit_y >= -32'sd1073741824 &&
      unit.unit_z <= 32'sd1073741824 && unit.unit_z >= -32'sd1073741824)
    else $error("unit component out of range");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    vec_stall |-> $past(unit_valid && unit_stall))
    else $error("input stalled without a held result");

endmodule

[rtl/vn_sqrt.sv]
module vn_sqrt (
  input  logic             clk,
  input  logic             en,
  input  logic [63:0]      radicand,
  input  vn_pkg::vn_side_t side_in,
  output logic [31:0]      root_out,
  output vn_pkg::vn_side_t side_out
);
  import vn_pkg::*;

  logic [32:0] rem  [1:SQRT_STAGES];
  logic [31:0] root [1:SQRT_STAGES];
  logic [63:0] rad  [1:SQRT_STAGES];
  vn_side_t    side [1:SQRT_STAGES];

  // One root bit per stage, two radicand bits brought down each time.
  for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
    logic [32:0] cur_rem;
    logic [31:0] cur_root;
    logic [63:0] cur_rad;
    vn_side_t    cur_side;
    logic [34:0] acc;
    logic [34:0] trial;
    logic        ge;

    if (i == 0) begin : g_first
      assign cur_rem  = '0;
      assign cur_root = '0;
      assign cur_rad  = radicand;
      assign cur_side = side_in;
    end else begin : g_rest
      assign cur_rem  = rem[i];
      assign cur_root = root[i];
      assign cur_rad  = rad[i];
      assign cur_side = side[i];
    end

    assign acc   = {cur_rem, cur_rad[63:62]};
    assign trial = {1'b0, cur_root, 2'b01};
    assign ge    = (acc >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]  <= ge ? 33'(acc - trial) : acc[32:0];
        root[i+1] <= {cur_root[30:0], ge};
        rad[i+1]  <= {cur_rad[61:0], 2'b00};
        side[i+1] <= cur_side;
      end
    end
  end

  assign root_out = root[SQRT_STAGES];
  assign side_out = side[SQRT_STAGES];

endmodule

[rtl/vn_div_lane.sv]
module vn_div_lane (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        mag,
  input  logic [4:0]         k,
  input  logic               neg,
  input  logic [31:0]        root,
  output logic signed [31:0] unit
);
  import vn_pkg::*;

  logic [31:0] ck;
  logic [62:0] dividend;
  logic [31:0] p_r;
  logic [30:0] p_dl;
  logic [31:0] p_m;
  logic        p_neg;

  logic [31:0] r   [1:DIV_STAGES];
  logic [30:0] q   [1:DIV_STAGES];
  logic [30:0] dl  [1:DIV_STAGES];
  logic [31:0] m   [1:DIV_STAGES];
  logic        sgn [1:DIV_STAGES];

  // |c| * 2^k never exceeds the root, so it fits in 32 bits.
  assign ck       = 32'({32'b0, mag} << k);
  assign dividend = {1'b0, ck, 30'b0} + {32'b0, root[31:1]};

  always_ff @(posedge clk) begin
    if (en) begin
      p_r   <= dividend[62:31];
      p_dl  <= dividend[30:0];
      p_m   <= root;
      p_neg <= neg;
    end
  end

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    logic [31:0] cur_r;
    logic [30:0] cur_q;
    logic [30:0] cur_dl;
    logic [31:0] cur_m;
    logic        cur_sgn;
    logic [32:0] acc;
    logic [32:0] diff;
    logic        ge;

    if (j == 0) begin : g_first
      assign cur_r   = p_r;
      assign cur_q   = '0;
      assign cur_dl  = p_dl;
      assign cur_m   = p_m;
      assign cur_sgn = p_neg;
    end else begin : g_rest
      assign cur_r   = r[j];
      assign cur_q   = q[j];
      assign cur_dl  = dl[j];
      assign cur_m   = m[j];
      assign cur_sgn = sgn[j];
    end

    assign acc  = {cur_r, cur_dl[30]};
    assign diff = acc - {1'b0, cur_m};
    assign ge   = (acc >= {1'b0, cur_m});

    always_ff @(posedge clk) begin
      if (en) begin
        r[j+1]   <= ge ? diff[31:0] : acc[31:0];
        q[j+1]   <= {cur_q[29:0], ge};
        dl[j+1]  <= {cur_dl[29:0], 1'b0};
        m[j+1]   <= cur_m;
        sgn[j+1] <= cur_sgn;
      end
    end
  end

  assign unit = sgn[DIV_STAGES] ? -$signed({1'b0, q[DIV_STAGES]})
                                :  $signed({1'b0, q[DIV_STAGES]});

endmodule

[tb/vector3_normalize_checker.sv]
module vector3_normalize_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               vec_valid,
  input  logic               vec_stall,
  input  vn_pkg::vec_word_t  vec,
  input  logic               unit_valid,
  input  logic               unit_stall,
  input  vn_pkg::unit_word_t unit,
  input  logic [15:0]        min_mag,
  output int                 fail_count,
  output int                 pending
);
  import vn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  unit_word_t expected_units[$];

  function automatic logic [63:0] root64(logic [63:0] s);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] scale_comp(logic signed [31:0] c, int k, logic [63:0] m);
    logic [63:0] mag;
    logic [63:0] q;
    mag = (c < 0) ? 64'(-64'(c)) : 64'(c);
    q = (((mag << k) << 30) + (m >> 1)) / m;
    if (c < 0) q = -q;
    return q[31:0];
  endfunction

  function automatic unit_word_t normalize(vec_word_t v, logic [15:0] thr);
    unit_word_t r;
    logic [63:0] ax, ay, az, s, sn, m;
    int k;
    ax = (v.comp_x < 0) ? 64'(-64'(v.comp_x)) : 64'(v.comp_x);
    ay = (v.comp_y < 0) ? 64'(-64'(v.comp_y)) : 64'(v.comp_y);
    az = (v.comp_z < 0) ? 64'(-64'(v.comp_z)) : 64'(v.comp_z);
    s = ax * ax + ay * ay + az * az;
    r = '0;
    if (s <= 64'(thr) * 64'(thr)) begin
      r.too_short = 1'b1;
      return r;
    end
    // Normalize S toward the top so the square root keeps full precision.
    sn = s;
    k = 0;
    while (k < 31 && sn[63:62] == 2'b00) begin
      sn = sn << 2;
      k++;
    end
    m = root64(sn);
    r.unit_x = scale_comp(v.comp_x, k, m);
    r.unit_y = scale_comp(v.comp_y, k, m);
    r.unit_z = scale_comp(v.comp_z, k, m);
    return r;
  endfunction

  assign pending = expected_units.size();

  always @(posedge clk) begin
    unit_word_t exp_w;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (vec_valid && !vec_stall) expected_units.push_back(normalize(vec, min_mag));
      if (unit_valid && !unit_stall) begin
        if (expected_units.size() == 0) begin
          if (fail_count < 10) $display("unexpected word %h", unit);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = expected_units.pop_front();
          if (exp_w !== unit) begin
            if (fail_count < 10)
              $display("mismatch: expected %h %h %h %b, got %h %h %h %b",
                       exp_w.unit_x, exp_w.unit_y, exp_w.unit_z, exp_w.too_short,
                       unit.unit_x, unit.unit_y, unit.unit_z, unit.too_short);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

[tb/vector3_normalize_tb.sv]
module vector3_normalize_tb;
  import vn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic vec_valid, vec_stall, unit_valid, unit_stall;
  vec_word_t vec;
  unit_word_t unit;
  logic [15:0] min_mag;
  int fail_count, pending;
  int send_idle_pct, recv_idle_pct;
  int hold_cycles;
  longint cycles;

  vector3_normalize uut (.*);

  vector3_normalize_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAIL vector3_normalize");
      $finish;
    end
  end

  // Receiver stall: random by percentage, or a long forced hold-off.
  always @(posedge clk) begin
    if (rst) begin
      unit_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      unit_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      unit_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic write_threshold(logic [15:0] value);
    @(posedge clk);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= PADDR_W'(REG_MIN_MAG) << 2;
    pwdata <= {16'($urandom_range(65535)), value};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    min_mag = value;
  endtask

  task automatic drain();
    vec_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 10) @(posedge clk);
  endtask

  // The word stays offered after acceptance until the next offer or a drain replaces it.
  task automatic offer(vec_word_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      vec_valid <= 0;
      @(posedge clk);
    end
    vec_valid <= 1;
    vec <= v;
    @(posedge clk);
    while (vec_stall) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(400)) - 200);
      2: return 32'($signed($urandom_range(131072)) - 65536);
      3: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return 32'($signed($urandom_range(1 << 24)) - (1 << 23));
    endcase
  endfunction

  task automatic random_items(int n);
    vec_word_t v;
    for (int i = 0; i < n; i++) begin
      v.comp_x = rand_comp(); v.comp_y = rand_comp(); v.comp_z = rand_comp();
      offer(v);
    end
  endtask

  initial begin
    vec_word_t v;
    logic [31:0] edges[8];
    cycles = 0; rst = 1; hold_cycles = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    vec_valid = 0; vec = '0;
    send_idle_pct = 0; recv_idle_pct = 0;
    min_mag = MIN_MAG_RESET;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    edges = '{32'h0, 32'h1, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff,
              32'd66, 32'd67, 32'h0001_0000};
    for (int i = 0; i < 8; i++) begin
      v.comp_x = edges[i]; v.comp_y = 0; v.comp_z = 0; offer(v);
      v.comp_x = 0; v.comp_y = edges[i]; v.comp_z = edges[7 - i]; offer(v);
    end
    v = {32'h8000_0000, 32'h8000_0000, 32'h8000_0000}; offer(v);
    v = {32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff}; offer(v);
    v = {32'd38, 32'd38, 32'd38}; offer(v);
    drain();

    write_threshold(16'd0);
    v = '0; offer(v);
    v = {32'h1, 32'h0, 32'h0}; offer(v);
    send_idle_pct = 32; recv_idle_pct = 53;
    random_items(300);
    drain();

    write_threshold(16'hffff);
    v = {32'h0000_ffff, 32'h0, 32'h0}; offer(v);
    v = {32'h0001_0000, 32'h0, 32'h0}; offer(v);
    send_idle_pct = 53; recv_idle_pct = 32;
    random_items(300);
    drain();

    write_threshold(16'd300);
    send_idle_pct = 0; recv_idle_pct = 0;
    hold_cycles = 200;
    random_items(400);
    drain();

    if (fail_count == 0) begin
      $display("PASS vector3_normalize");
    end else begin
      $display("FAIL vector3_normalize");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/vn_pkg.sv
rtl/vn_sqrt.sv
rtl/vn_div_lane.sv
rtl/vector3_normalize.sv
tb/vector3_normalize_checker.sv
tb/vector3_normalize_tb.sv
